[src/sumo_reactive_drive_controller_top_macros.svh]
// Assertion macros used by the file that checks this block.
`ifndef SUMO_REACTIVE_DRIVE_CONTROLLER_TOP_MACROS_SVH
`define SUMO_REACTIVE_DRIVE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srdc: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srdc: next-cycle check failed");

`endif

[src/srdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srdc_pkg;

    localparam int IN_W  = 48;
    localparam int OUT_W = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W = 16;

    typedef logic signed [10:0] speed_t;
    typedef logic [2:0] cmd_t;
    typedef logic [2:0] led_t;
    typedef logic [2:0] mode_t;

    localparam cmd_t CMD_NONE  = 3'd0;
    localparam cmd_t CMD_READY = 3'd1;
    localparam cmd_t CMD_RUN   = 3'd2;
    localparam cmd_t CMD_STOP  = 3'd3;
    localparam cmd_t CMD_ARC   = 3'd4;
    localparam cmd_t CMD_FWD   = 3'd5;
    localparam cmd_t CMD_S180  = 3'd6;
    localparam cmd_t CMD_S0    = 3'd7;

    localparam led_t LED_NONE    = 3'd0;
    localparam led_t LED_GREEN   = 3'd1;
    localparam led_t LED_RED     = 3'd2;
    localparam led_t LED_MAGENTA = 3'd3;
    localparam led_t LED_WHITE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TURN_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_TIME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REV_BOTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REV_SIDE     = 3'd4;

    localparam logic [CFG_W-1:0] RST_TURN_TIME = 16'd100;
    localparam logic [CFG_W-1:0] RST_ARC_TIME  = 16'd200;
    localparam logic [CFG_W-1:0] RST_FWD_TIME  = 16'd150;
    localparam logic [CFG_W-1:0] RST_REV_BOTH  = 16'd200;
    localparam logic [CFG_W-1:0] RST_REV_SIDE  = 16'd300;

    localparam logic [7:0] SERVO_CENTRE = 8'd90;
    localparam logic [7:0] SERVO_MAX    = 8'd180;
    localparam logic [7:0] SERVO_MIN    = 8'd0;

    localparam speed_t SPD_0     = 11'sd0;
    localparam speed_t SPD_200   = 11'sd200;
    localparam speed_t SPD_300   = 11'sd300;
    localparam speed_t SPD_320   = 11'sd320;
    localparam speed_t SPD_400   = 11'sd400;
    localparam speed_t SPD_500   = 11'sd500;
    localparam speed_t SPD_600   = 11'sd600;
    localparam speed_t SPD_700   = 11'sd700;
    localparam speed_t SPD_800   = 11'sd800;
    localparam speed_t SPD_1000  = 11'sd1000;
    localparam speed_t SPD_N250  = -11'sd250;
    localparam speed_t SPD_N400  = -11'sd400;
    localparam speed_t SPD_N500  = -11'sd500;
    localparam speed_t SPD_N700  = -11'sd700;

endpackage

`default_nettype wire

[src/sumo_reactive_drive_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Reactive drive controller for a sumo robot. Each request on the slave stream is one pass of
// the control loop and yields exactly one request on the master stream in the cycle after it is
// taken. A new pass can be taken in every cycle in which the result register is empty or its
// request is taken by the master side at that same edge, so the result register is emptied and
// refilled together; while the master side holds a result back, the slave side waits.
// Throughput is one pass per clock while the master side takes each result, set by the single
// result register; the whole pass (mode filter, opening strategy, edge reverse, enemy search)
// is worked out between the slave port and that register. The user must write timing registers
// only while no pass is in flight, via the always-ready configuration channel (not enforced).

module sumo_reactive_drive_controller_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // remote_cmd[2:0], enemy_bits[7:3], edge_right[8], edge_left[9], now_ms[41:10], zero pad
    input  wire logic [srdc_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // drive_valid[0], speed_right[11:1], speed_left[22:12], servo_write[23],
    // servo_target[31:24], led_code[34:32], zero pad
    output logic [srdc_pkg::OUT_W-1:0]          m_axis_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [srdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [srdc_pkg::CFG_W-1:0]     cfg_data
);

    logic [15:0] turn_time_reg;
    logic [15:0] arc_time_reg;
    logic [15:0] fwd_time_reg;
    logic [15:0] rev_both_reg;
    logic [15:0] rev_side_reg;

    srdc_pkg::mode_t    mode_reg, mode_next;
    logic               sel_reg, sel_next;
    logic [7:0]         servo_angle_reg, servo_angle_next;
    logic               servo_done_reg, servo_done_next;
    logic               strat_started_reg, strat_started_next;
    logic               strat_finished_reg, strat_finished_next;
    logic [31:0]        strat_start_reg, strat_start_next;
    logic               line_now_reg, line_now_next;
    logic               line_prev_reg, line_prev_next;
    logic [31:0]        rev_start_reg, rev_start_next;
    logic [15:0]        rev_len_reg, rev_len_next;
    logic               rev_act_reg, rev_act_next;
    logic               turning_reg, turning_next;
    logic [31:0]        turn_start_reg, turn_start_next;
    logic [4:0]         last_enemy_reg, last_enemy_next;
    srdc_pkg::speed_t   held_right_reg, held_right_next;
    srdc_pkg::speed_t   held_left_reg, held_left_next;

    logic                          out_valid_reg;
    logic [srdc_pkg::OUT_W-1:0]    out_data_reg;
    logic [srdc_pkg::OUT_W-1:0]    out_data_next;

    srdc_pkg::cmd_t     cmd_in;
    srdc_pkg::cmd_t     cmd;
    logic [4:0]         e;
    logic [4:0]         p;
    logic               er;
    logic               el;
    logic [31:0]        now;
    logic [15:0]        strat_len;
    logic [31:0]        elapsed_strat;
    logic [31:0]        elapsed_rev;
    logic [31:0]        elapsed_turn;
    logic               dv;
    logic               sw;
    logic [7:0]         st;
    srdc_pkg::led_t     led;
    srdc_pkg::speed_t   sr;
    srdc_pkg::speed_t   sl;
    logic               in_acc;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    assign cmd_in = s_axis_tdata[2:0];
    assign e      = s_axis_tdata[7:3];
    assign er     = s_axis_tdata[8];
    assign el     = s_axis_tdata[9];
    assign now    = s_axis_tdata[41:10];
    assign p      = last_enemy_reg;

    always_comb
    begin
        mode_next           = mode_reg;
        sel_next            = sel_reg;
        servo_angle_next    = servo_angle_reg;
        servo_done_next     = servo_done_reg;
        strat_started_next  = strat_started_reg;
        strat_finished_next = strat_finished_reg;
        strat_start_next    = strat_start_reg;
        line_now_next       = line_now_reg;
        line_prev_next      = line_prev_reg;
        rev_start_next      = rev_start_reg;
        rev_len_next        = rev_len_reg;
        rev_act_next        = rev_act_reg;
        turning_next        = turning_reg;
        turn_start_next     = turn_start_reg;
        last_enemy_next     = last_enemy_reg;
        held_right_next     = held_right_reg;
        held_left_next      = held_left_reg;
        strat_len           = '0;
        elapsed_strat       = '0;
        elapsed_rev         = '0;
        elapsed_turn        = '0;
        dv                  = 1'b0;
        sw                  = 1'b0;
        st                  = '0;
        led                 = srdc_pkg::LED_NONE;
        sr                  = srdc_pkg::SPD_0;
        sl                  = srdc_pkg::SPD_0;

        // Once running, everything but stop reads as run; once stopped, everything is stop.
        if (mode_reg == srdc_pkg::CMD_RUN && cmd_in != srdc_pkg::CMD_STOP)
        begin
            cmd = srdc_pkg::CMD_RUN;
        end
        else if (mode_reg == srdc_pkg::CMD_STOP)
        begin
            cmd = srdc_pkg::CMD_STOP;
        end
        else
        begin
            cmd = cmd_in;
        end

        unique case (cmd) inside
            srdc_pkg::CMD_READY:
            begin
                mode_next      = srdc_pkg::CMD_READY;
                led            = srdc_pkg::LED_GREEN;
                rev_start_next = now;
            end
            srdc_pkg::CMD_RUN:
            begin
                if (!servo_done_reg)
                begin
                    sw              = 1'b1;
                    st              = servo_angle_reg;
                    servo_done_next = 1'b1;
                end

                // Opening strategy.
                if (!strat_started_reg)
                begin
                    strat_start_next   = now;
                    strat_started_next = 1'b1;
                end
                if (!strat_finished_reg)
                begin
                    strat_len     = sel_reg ? fwd_time_reg : arc_time_reg;
                    elapsed_strat = now - strat_start_next;
                    if (elapsed_strat <= {16'd0, strat_len})
                    begin
                        held_right_next = srdc_pkg::SPD_400;
                        held_left_next  = sel_reg ? srdc_pkg::SPD_400 : srdc_pkg::SPD_300;
                    end
                    else
                    begin
                        strat_finished_next = 1'b1;
                    end
                end

                // Edge watch; the reverse start time lags the edge state by one pass.
                if (line_now_reg != line_prev_reg)
                begin
                    rev_start_next = now;
                end
                line_prev_next = line_now_reg;
                if (er || el)
                begin
                    rev_len_next  = rev_both_reg;
                    line_now_next = 1'b1;
                    rev_act_next  = 1'b1;
                end
                else
                begin
                    line_now_next = 1'b0;
                end

                // Reverse manoeuvre.
                elapsed_rev = now - rev_start_next;
                if (rev_act_next && elapsed_rev < {16'd0, rev_len_next})
                begin
                    if (er && el)
                    begin
                        rev_len_next    = rev_both_reg;
                        held_right_next = srdc_pkg::SPD_N500;
                        held_left_next  = srdc_pkg::SPD_N500;
                    end
                    else if (er)
                    begin
                        rev_len_next    = rev_side_reg;
                        held_right_next = srdc_pkg::SPD_N700;
                        held_left_next  = srdc_pkg::SPD_N250;
                    end
                    else if (el)
                    begin
                        rev_len_next    = rev_side_reg;
                        held_right_next = srdc_pkg::SPD_N250;
                        held_left_next  = srdc_pkg::SPD_N500;
                    end
                    else
                    begin
                        held_right_next = srdc_pkg::SPD_N400;
                        held_left_next  = srdc_pkg::SPD_N400;
                    end
                end
                else
                begin
                    rev_len_next = '0;
                    rev_act_next = 1'b0;
                end

                // Enemy search and attack.
                if (rev_act_next)
                begin
                    if (e[0])
                    begin
                        held_right_next = srdc_pkg::SPD_0;
                        held_left_next  = srdc_pkg::SPD_500;
                        last_enemy_next = e;
                    end
                    else if (e[4])
                    begin
                        held_right_next = srdc_pkg::SPD_500;
                        held_left_next  = srdc_pkg::SPD_0;
                        last_enemy_next = e;
                    end
                    else if (e[1] && e[2] && e[3])
                    begin
                        held_right_next = srdc_pkg::SPD_1000;
                        held_left_next  = srdc_pkg::SPD_1000;
                        last_enemy_next = e;
                    end
                    else if (e[2])
                    begin
                        held_right_next = srdc_pkg::SPD_700;
                        held_left_next  = srdc_pkg::SPD_700;
                        last_enemy_next = e;
                    end
                end
                else if (e == 5'd0)
                begin
                    if (!turning_reg)
                    begin
                        turn_start_next = now;
                        turning_next    = 1'b1;
                        if ((p[1] && p[2] && p[3]) ||
                            (p[2] && !p[1] && !p[3] && !p[4] && !p[0]))
                        begin
                            held_right_next = srdc_pkg::SPD_300;
                            held_left_next  = srdc_pkg::SPD_300;
                        end
                        else if (p[1] && p[2])
                        begin
                            held_right_next = srdc_pkg::SPD_320;
                            held_left_next  = srdc_pkg::SPD_400;
                        end
                        else if (p[2] && p[3])
                        begin
                            held_right_next = srdc_pkg::SPD_400;
                            held_left_next  = srdc_pkg::SPD_320;
                        end
                        else if (p[0])
                        begin
                            held_right_next = srdc_pkg::SPD_0;
                            held_left_next  = srdc_pkg::SPD_400;
                        end
                        else if (p[4])
                        begin
                            held_right_next = srdc_pkg::SPD_400;
                            held_left_next  = srdc_pkg::SPD_0;
                        end
                        else
                        begin
                            held_right_next = srdc_pkg::SPD_200;
                            held_left_next  = srdc_pkg::SPD_200;
                        end
                    end
                    elapsed_turn = now - turn_start_next;
                    if (turning_next && elapsed_turn >= {16'd0, turn_time_reg})
                    begin
                        turning_next    = 1'b0;
                        held_right_next = srdc_pkg::SPD_400;
                        held_left_next  = srdc_pkg::SPD_400;
                    end
                end
                else
                begin
                    turning_next = 1'b0;
                    if (e[0] && e[1])
                    begin
                        held_right_next = srdc_pkg::SPD_300;
                        held_left_next  = srdc_pkg::SPD_600;
                    end
                    else if (e[0])
                    begin
                        held_right_next = srdc_pkg::SPD_0;
                        held_left_next  = srdc_pkg::SPD_500;
                    end
                    else if (e[3] && e[4])
                    begin
                        held_right_next = srdc_pkg::SPD_600;
                        held_left_next  = srdc_pkg::SPD_300;
                    end
                    else if (e[4])
                    begin
                        held_right_next = srdc_pkg::SPD_500;
                        held_left_next  = srdc_pkg::SPD_0;
                    end
                    else if ((e[1] && e[2]) || (e[2] && e[3]))
                    begin
                        held_right_next = srdc_pkg::SPD_1000;
                        held_left_next  = srdc_pkg::SPD_1000;
                    end
                    else if (e[2])
                    begin
                        held_right_next = srdc_pkg::SPD_800;
                        held_left_next  = srdc_pkg::SPD_800;
                    end
                    last_enemy_next = e;
                end

                dv        = 1'b1;
                sr        = held_right_next;
                sl        = held_left_next;
                mode_next = srdc_pkg::CMD_RUN;
            end
            srdc_pkg::CMD_STOP:
            begin
                dv                  = 1'b1;
                led                 = srdc_pkg::LED_RED;
                rev_len_next        = '0;
                rev_act_next        = 1'b0;
                mode_next           = srdc_pkg::CMD_STOP;
                strat_started_next  = 1'b0;
                strat_finished_next = 1'b0;
            end
            srdc_pkg::CMD_ARC, srdc_pkg::CMD_FWD:
            begin
                sel_next  = cmd[0];
                mode_next = cmd;
                led       = srdc_pkg::LED_MAGENTA;
            end
            srdc_pkg::CMD_S180, srdc_pkg::CMD_S0:
            begin
                servo_angle_next = (cmd == srdc_pkg::CMD_S180) ? srdc_pkg::SERVO_MAX
                                                               : srdc_pkg::SERVO_MIN;
                led              = srdc_pkg::LED_WHITE;
                mode_next        = cmd;
            end
            default:
            begin
            end
        endcase

        out_data_next = {5'd0, led, st, sw, sl, sr, dv};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_time_reg <= srdc_pkg::RST_TURN_TIME;
            arc_time_reg  <= srdc_pkg::RST_ARC_TIME;
            fwd_time_reg  <= srdc_pkg::RST_FWD_TIME;
            rev_both_reg  <= srdc_pkg::RST_REV_BOTH;
            rev_side_reg  <= srdc_pkg::RST_REV_SIDE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                srdc_pkg::REG_TURN_TIME: turn_time_reg <= cfg_data;
                srdc_pkg::REG_ARC_TIME:  arc_time_reg  <= cfg_data;
                srdc_pkg::REG_FWD_TIME:  fwd_time_reg  <= cfg_data;
                srdc_pkg::REG_REV_BOTH:  rev_both_reg  <= cfg_data;
                srdc_pkg::REG_REV_SIDE:  rev_side_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= srdc_pkg::CMD_NONE;
            sel_reg            <= 1'b0;
            servo_angle_reg    <= srdc_pkg::SERVO_CENTRE;
            servo_done_reg     <= 1'b0;
            strat_started_reg  <= 1'b0;
            strat_finished_reg <= 1'b0;
            strat_start_reg    <= '0;
            line_now_reg       <= 1'b0;
            line_prev_reg      <= 1'b0;
            rev_start_reg      <= '0;
            rev_len_reg        <= '0;
            rev_act_reg        <= 1'b0;
            turning_reg        <= 1'b0;
            turn_start_reg     <= '0;
            last_enemy_reg     <= '0;
            held_right_reg     <= srdc_pkg::SPD_0;
            held_left_reg      <= srdc_pkg::SPD_0;
        end
        else if (in_acc)
        begin
            mode_reg           <= mode_next;
            sel_reg            <= sel_next;
            servo_angle_reg    <= servo_angle_next;
            servo_done_reg     <= servo_done_next;
            strat_started_reg  <= strat_started_next;
            strat_finished_reg <= strat_finished_next;
            strat_start_reg    <= strat_start_next;
            line_now_reg       <= line_now_next;
            line_prev_reg      <= line_prev_next;
            rev_start_reg      <= rev_start_next;
            rev_len_reg        <= rev_len_next;
            rev_act_reg        <= rev_act_next;
            turning_reg        <= turning_next;
            turn_start_reg     <= turn_start_next;
            last_enemy_reg     <= last_enemy_next;
            held_right_reg     <= held_right_next;
            held_left_reg      <= held_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg <= out_data_next;
        end
    end

`include "sumo_reactive_drive_controller_top_macros.svh"

    `SRDC_ASSERT_NEXT(a_stop_sticky, mode_reg == srdc_pkg::CMD_STOP, mode_reg == srdc_pkg::CMD_STOP)
    `SRDC_ASSERT_NEXT(a_servo_once, in_acc && servo_done_reg, !m_axis_tdata[23])
    `SRDC_ASSERT_SAME(a_rev_len_active, rev_len_reg != 16'd0, rev_act_reg)
    `SRDC_ASSERT_SAME(a_idle_speeds, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[22:1] == 22'd0)

endmodule

`default_nettype wire
